// ===== sv/pe_pkg.sv =====
// ----------------------------------------------------------------------------
// pe_pkg
// Shared types and constants of the polynomial evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pe_pkg;

  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int X_W        = 16;
  localparam int ACC_W      = 32;
  localparam int PROD_W     = ACC_W + X_W;
  localparam int FRAC_SHIFT = 8;
  localparam int SUM_W      = PROD_W - FRAC_SHIFT + 2;

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sh7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(64'sh8000_0000);

  // Horner accumulator with the point and the sticky saturation flag.
  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic signed [X_W-1:0]   x;
    logic                    ovf;
  } pe_item_t;

endpackage

`default_nettype wire

// ===== sv/pe_if.sv =====
// ----------------------------------------------------------------------------
// pe_x_if / pe_y_if
// Valid/ready channels for evaluation points and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pe_x_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_value;

  modport source (output valid, output x_value, input ready);
  modport sink   (input valid, input x_value, output ready);
endinterface

interface pe_y_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] y_value;
  logic               overflow;

  modport source (output valid, output y_value, output overflow, input ready);
  modport sink   (input valid, input y_value, input overflow, output ready);
endinterface

`default_nettype wire

// ===== sv/pe_step.sv =====
// ----------------------------------------------------------------------------
// pe_step
// One Horner step in two stages: multiply by x, then round, add and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module pe_step import pe_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire pe_item_t                in_item,
  input  wire logic signed [ACC_W-1:0] coeff,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output pe_item_t                     out_item
);

  logic                     m_valid;
  logic signed [PROD_W-1:0] m_prod;
  logic signed [X_W-1:0]    m_x;
  logic                     m_ovf;
  logic                     m_en;
  logic                     a_en;

  logic signed [PROD_W:0]   rnd;
  logic signed [SUM_W-1:0]  sum;
  logic                     sat_hi;
  logic                     sat_lo;
  pe_item_t                 a_next;

  assign a_en     = !out_valid || out_ready;
  assign m_en     = !m_valid || a_en;
  assign in_ready = m_en;

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_en) begin
      m_valid <= in_valid;
    end
    if (m_en && in_valid) begin
      m_prod <= PROD_W'(in_item.acc) * PROD_W'(in_item.x);
      m_x    <= in_item.x;
      m_ovf  <= in_item.ovf;
    end
  end

  // round half up, floor by arithmetic shift, add the coefficient, clamp
  always_comb begin
    rnd    = (PROD_W+1)'(m_prod) + (PROD_W+1)'(1 << (FRAC_SHIFT - 1));
    sum    = SUM_W'(rnd >>> FRAC_SHIFT) + SUM_W'(coeff);
    sat_hi = sum > SAT_MAX;
    sat_lo = sum < SAT_MIN;
    a_next.x   = m_x;
    a_next.ovf = m_ovf || sat_hi || sat_lo;
    if (sat_hi) begin
      a_next.acc = ACC_W'(SAT_MAX);
    end else if (sat_lo) begin
      a_next.acc = ACC_W'(SAT_MIN);
    end else begin
      a_next.acc = ACC_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_en) begin
      out_valid <= m_valid;
    end
    if (a_en && m_valid) begin
      out_item <= a_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/polynomial_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// polynomial_evaluator_core
// Fixed-point Horner evaluation of a polynomial with programmable coefficients.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  x_chan    in   valid / ready    x_value   Q8.8 signed
//  y_chan    out  valid / ready    y_value   Q16.16 signed, overflow
//  cfg       in   cfg_we           cfg_index, cfg_data (coeff_0 .. coeff_7)
//
//  One point per cycle is taken while y_chan is not stalled. The path is
//  a load stage, then a multiply stage and an add/saturate stage per step.
//  Each stage holds while the one after it is full and stalled, so a stall
//  drops and repeats nothing and bubbles are squeezed out.
//  Reset clears the coefficients and all stage valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module polynomial_evaluator_core import pe_pkg::*; #(
  parameter int COEFF_COUNT = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ACC_W-1:0]     cfg_data,
  pe_x_if.sink                      x_chan,
  pe_y_if.source                    y_chan
);

  localparam int STEPS = COEFF_COUNT - 1;

  logic signed [ACC_W-1:0] coeff_reg [NUM_REGS];

  logic     vld  [STEPS+1];
  logic     rdy  [STEPS+1];
  pe_item_t item [STEPS+1];
  logic     en0;
  logic     load_valid;
  pe_item_t load_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coeff_reg[i] <= '0;
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      coeff_reg[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
    end
  end

  // load stage: accumulator starts at the top coefficient
  assign en0          = !load_valid || rdy[0];
  assign x_chan.ready = en0;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_valid <= 1'b0;
    end else if (en0) begin
      load_valid <= x_chan.valid;
    end
    if (en0 && x_chan.valid) begin
      load_item.acc <= coeff_reg[STEPS];
      load_item.x   <= x_chan.x_value;
      load_item.ovf <= 1'b0;
    end
  end

  assign vld[0]  = load_valid;
  assign item[0] = load_item;

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    pe_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[j]),
      .in_ready  (rdy[j]),
      .in_item   (item[j]),
      .coeff     (coeff_reg[STEPS-1-j]),
      .out_valid (vld[j+1]),
      .out_ready (rdy[j+1]),
      .out_item  (item[j+1])
    );
  end

  assign rdy[STEPS]      = y_chan.ready;
  assign y_chan.valid    = vld[STEPS];
  assign y_chan.y_value  = item[STEPS].acc;
  assign y_chan.overflow = item[STEPS].ovf;

endmodule

`default_nettype wire
